@@ hw/rtl/tsss_pkg.sv @@
// Shared types, constants and helpers of the TDMA slot keeper.
package tsss_pkg;

    localparam int MAX_NODES_DEF    = 32;
    localparam int SLOT_TICKS_DEF   = 7;
    localparam int MISS_LIMIT_DEF   = 3;
    localparam int MAX_CHANNELS_DEF = 16;
    localparam int CMDQ_DEPTH_DEF   = 4;

    localparam int NID_W  = 6;
    localparam int FROM_W = 8;
    localparam int CNT_W  = 16;
    localparam int BYTE_W = 8;
    localparam int HOP_W  = 4;
    localparam int EIDX_W = 5;
    localparam int TMR_W  = 9;
    localparam int CC_W   = 5;
    localparam int MISS_W = 2;
    localparam int CALC_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 48;

    localparam int FIRST_BASE = 255;
    localparam int TX_GUARD   = 3;

    localparam logic [NID_W-1:0]  NODE_ID_RST       = NID_W'(1);
    localparam logic [NID_W-1:0]  NUM_NODES_RST     = NID_W'(1);
    localparam logic [CC_W-1:0]   CHANNEL_COUNT_RST = CC_W'(4);
    localparam logic [BYTE_W-1:0] HOLE_VALUE_RST    = BYTE_W'(127);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_ID       = 2'd0,
        CFG_NUM_NODES     = 2'd1,
        CFG_CHANNEL_COUNT = 2'd2,
        CFG_HOLE_VALUE    = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_STORE = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              ch_fire;
        logic              tx_fire;
        logic [HOP_W-1:0]  hop;
        logic              flush;
        logic [CNT_W-1:0]  counter;
        logic [NID_W-1:0]  n;
        logic [NID_W-1:0]  slot;
        logic [BYTE_W-1:0] rss;
        logic [BYTE_W-1:0] corr;
    } t_cmd;

    function automatic logic [TMR_W-1:0] clamp_limit(input logic signed [CALC_W-1:0] v);
        logic signed [CALC_W-1:0] hi;
        hi = CALC_W'((2 ** TMR_W) - 1);
        if (v <= 0) begin
            return '0;
        end else if (v > hi) begin
            return hi[TMR_W-1:0];
        end
        return v[TMR_W-1:0];
    endfunction

endpackage

@@ hw/rtl/tsss_ram.sv @@
// Generic single-port-write RAM with registered read.
module tsss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/tsss_front.sv @@
// Front end: config registers, timers, hop and miss tracking, command generation.
module tsss_front
    import tsss_pkg::*;
#(
    parameter int MAX_NODES    = MAX_NODES_DEF,
    parameter int SLOT_TICKS   = SLOT_TICKS_DEF,
    parameter int MISS_LIMIT   = MISS_LIMIT_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_action,
    input  logic [FROM_W-1:0]     i_from_node,
    input  logic [CNT_W-1:0]      i_rx_counter,
    input  logic [BYTE_W-1:0]     i_rx_rssi,
    input  logic [BYTE_W-1:0]     i_rx_corr,
    input  logic                  i_length_matches,
    input  logic                  i_full,
    output logic                  o_push,
    output t_cmd                  o_cmd,
    output logic [BYTE_W-1:0]     o_hole_value
);

    localparam logic signed [CALC_W-1:0] SLOT_S  = CALC_W'(SLOT_TICKS);
    localparam logic signed [CALC_W-1:0] C_ONE   = CALC_W'(1);
    localparam logic signed [CALC_W-1:0] C_TWO   = CALC_W'(2);
    localparam logic signed [CALC_W-1:0] C_GUARD = CALC_W'(TX_GUARD);
    localparam logic signed [CALC_W-1:0] C_FIRST = CALC_W'(FIRST_BASE);
    localparam logic [NID_W-1:0]  MAX_N   = NID_W'(MAX_NODES);
    localparam logic [CC_W-1:0]   MAX_CH  = CC_W'(MAX_CHANNELS);
    localparam logic [MISS_W-1:0] MISS_LIM = MISS_W'(MISS_LIMIT);

    logic [NID_W-1:0]  r_node_id;
    logic [NID_W-1:0]  r_num_nodes;
    logic [CC_W-1:0]   r_channel_count;
    logic [BYTE_W-1:0] r_hole_value;

    logic [TMR_W-1:0]  r_tx_elapsed, n_tx_elapsed;
    logic [TMR_W-1:0]  r_tx_limit, n_tx_limit;
    logic              r_first, n_first;
    logic              r_tx_running, n_tx_running;
    logic [TMR_W-1:0]  r_ch_elapsed, n_ch_elapsed;
    logic [TMR_W-1:0]  r_ch_limit, n_ch_limit;
    logic              r_ch_running, n_ch_running;
    logic [HOP_W-1:0]  r_hop, n_hop;
    logic [MISS_W-1:0] r_miss, n_miss;
    logic [CNT_W-1:0]  r_own_counter, n_own_counter;

    logic                     acc;
    logic [NID_W-1:0]         n_eff;
    logic signed [CALC_W-1:0] s_n, s_t, s_me;
    logic                     sender_ok, after_me;
    logic [TMR_W-1:0]         ch_lim_rx, tx_lim_late, tx_lim_early, reload, first_lim, tx_lim;
    logic [TMR_W-1:0]         ch_e, tx_e;
    logic                     ch_fire, tx_fire, miss_lt;
    logic [CC_W-1:0]          hop_inc;
    logic [HOP_W-1:0]         hop_new;

    assign o_ready      = !i_full;
    assign acc          = i_valid && !i_full;
    assign o_hole_value = r_hole_value;

    assign n_eff = (r_num_nodes > MAX_N) ? MAX_N : r_num_nodes;
    assign s_n   = CALC_W'(n_eff);
    assign s_t   = CALC_W'(i_from_node);
    assign s_me  = CALC_W'(r_node_id);

    assign sender_ok = i_from_node inside {[FROM_W'(1) : FROM_W'(n_eff)]};
    assign after_me  = i_from_node > FROM_W'(r_node_id);

    assign ch_lim_rx    = clamp_limit(CALC_W'((s_n - s_t + C_TWO) * SLOT_S));
    assign tx_lim_late  = clamp_limit(CALC_W'((s_n - s_t + s_me - C_ONE + C_GUARD) * SLOT_S));
    assign tx_lim_early = clamp_limit(CALC_W'((s_me - C_ONE - s_t) * SLOT_S));
    assign reload       = clamp_limit(CALC_W'((s_n + C_GUARD) * SLOT_S));
    assign first_lim    = clamp_limit(CALC_W'(C_FIRST - s_me * SLOT_S));
    assign tx_lim       = r_first ? first_lim : r_tx_limit;

    assign ch_e    = r_ch_elapsed + TMR_W'(1);
    assign tx_e    = r_tx_elapsed + TMR_W'(1);
    assign ch_fire = r_ch_running && (ch_e >= r_ch_limit);
    assign tx_fire = r_tx_running && (tx_e >= tx_lim);
    assign miss_lt = r_miss < MISS_LIM;
    assign hop_inc = CC_W'(r_hop) + CC_W'(1);

    always_comb begin
        if (!miss_lt) begin
            hop_new = '0;
        end else if (hop_inc >= r_channel_count || hop_inc >= MAX_CH) begin
            hop_new = '0;
        end else begin
            hop_new = hop_inc[HOP_W-1:0];
        end
    end

    always_comb begin
        n_tx_elapsed  = r_tx_elapsed;
        n_tx_limit    = r_tx_limit;
        n_first       = r_first;
        n_tx_running  = r_tx_running;
        n_ch_elapsed  = r_ch_elapsed;
        n_ch_limit    = r_ch_limit;
        n_ch_running  = r_ch_running;
        n_hop         = r_hop;
        n_miss        = r_miss;
        n_own_counter = r_own_counter;
        o_push        = 1'b0;
        o_cmd         = '0;
        if (acc) begin
            if (i_action) begin
                if (i_length_matches) begin
                    n_tx_running = 1'b0;
                    n_ch_running = 1'b0;
                    n_miss       = '0;
                    if (sender_ok) begin
                        n_ch_limit   = ch_lim_rx;
                        n_ch_elapsed = '0;
                        n_ch_running = 1'b1;
                        if (after_me) begin
                            n_tx_limit    = tx_lim_late;
                            n_own_counter = i_rx_counter + CNT_W'(n_eff)
                                            - CNT_W'(i_from_node) + CNT_W'(1);
                        end else begin
                            n_tx_limit    = tx_lim_early;
                            n_own_counter = i_rx_counter + CNT_W'(r_node_id)
                                            - CNT_W'(i_from_node);
                        end
                        n_first      = 1'b0;
                        n_tx_elapsed = '0;
                        n_tx_running = 1'b1;
                        o_push       = 1'b1;
                        o_cmd.op     = OP_STORE;
                        o_cmd.slot   = NID_W'(i_from_node - FROM_W'(1));
                        o_cmd.rss    = i_rx_rssi;
                        o_cmd.corr   = i_rx_corr;
                    end
                end
            end else begin
                if (r_ch_running) begin
                    n_ch_elapsed = ch_fire ? '0 : ch_e;
                end
                if (r_tx_running) begin
                    n_tx_elapsed = tx_fire ? '0 : tx_e;
                end
                if (ch_fire) begin
                    n_hop      = hop_new;
                    n_ch_limit = reload;
                end
                if (tx_fire) begin
                    if (miss_lt) begin
                        n_miss = r_miss + MISS_W'(1);
                    end
                    n_tx_limit = reload;
                    n_first    = 1'b0;
                end
                o_push        = ch_fire || tx_fire;
                o_cmd.op      = OP_TICK;
                o_cmd.ch_fire = ch_fire;
                o_cmd.tx_fire = tx_fire;
                o_cmd.hop     = ch_fire ? hop_new : r_hop;
                o_cmd.flush   = !miss_lt;
                o_cmd.counter = r_own_counter;
                o_cmd.n       = n_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id       <= NODE_ID_RST;
            r_num_nodes     <= NUM_NODES_RST;
            r_channel_count <= CHANNEL_COUNT_RST;
            r_hole_value    <= HOLE_VALUE_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_NODE_ID:       r_node_id       <= i_cfg_data[NID_W-1:0];
                CFG_NUM_NODES:     r_num_nodes     <= i_cfg_data[NID_W-1:0];
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[CC_W-1:0];
                CFG_HOLE_VALUE:    r_hole_value    <= i_cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_elapsed  <= '0;
            r_tx_limit    <= '0;
            r_first       <= 1'b1;
            r_tx_running  <= 1'b1;
            r_ch_elapsed  <= '0;
            r_ch_limit    <= '0;
            r_ch_running  <= 1'b0;
            r_hop         <= '0;
            r_miss        <= '0;
            r_own_counter <= '0;
        end else begin
            r_tx_elapsed  <= n_tx_elapsed;
            r_tx_limit    <= n_tx_limit;
            r_first       <= n_first;
            r_tx_running  <= n_tx_running;
            r_ch_elapsed  <= n_ch_elapsed;
            r_ch_limit    <= n_ch_limit;
            r_ch_running  <= n_ch_running;
            r_hop         <= n_hop;
            r_miss        <= n_miss;
            r_own_counter <= n_own_counter;
        end
    end

`ifndef SYNTHESIS
    a_miss_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_miss <= MISS_LIM)
        else $error("miss count above limit");
    a_pkt_stops_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_action && i_length_matches && !sender_ok) |=> (!r_tx_running && !r_ch_running))
        else $error("timers still running after invalid sender");
`endif

endmodule

@@ hw/rtl/tsss_cmdq.sv @@
// Small command queue between the front end and the result sequencer.
module tsss_cmdq
    import tsss_pkg::*;
#(
    parameter int DEPTH = CMDQ_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full command queue");
`endif

endmodule

@@ hw/rtl/tsss_back.sv @@
// Back end: entry store, channel-change and packet-entry result sequencer.
module tsss_back
    import tsss_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_empty,
    output logic              o_pop,
    input  logic [BYTE_W-1:0] i_hole_value,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_kind,
    output logic [HOP_W-1:0]  o_channel_index,
    output logic              o_flush_rx,
    output logic [CNT_W-1:0]  o_header_counter,
    output logic [EIDX_W-1:0] o_entry_index,
    output logic [BYTE_W-1:0] o_entry_rss,
    output logic [BYTE_W-1:0] o_entry_corr,
    output logic              o_last
);

    localparam int AW = $clog2(MAX_NODES);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CHAN = 3'b010,
        S_TX   = 3'b100
    } t_bstate;

    t_bstate            r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [NID_W-1:0]   r_idx, n_idx;
    logic [NID_W-1:0]   r_cur, n_cur;
    logic               r_cur_v, n_cur_v;
    logic               r_have, n_have;
    logic [MAX_NODES-1:0] r_valid;

    logic               r_out_valid, n_out_valid;
    logic               r_kind, n_kind;
    logic [HOP_W-1:0]   r_ch, n_ch;
    logic               r_fl, n_fl;
    logic [CNT_W-1:0]   r_hc, n_hc;
    logic [EIDX_W-1:0]  r_ei, n_ei;
    logic [BYTE_W-1:0]  r_rss, n_rss;
    logic [BYTE_W-1:0]  r_corr, n_corr;
    logic               r_last, n_last;

    logic                  out_free, load, issue, entry_last;
    logic                  set_valid, clr_valid;
    logic                  ram_we, ram_re;
    logic [2*BYTE_W-1:0]   ram_rdata;

    assign out_free   = !r_out_valid || i_ready;
    assign entry_last = r_cur == (r_cmd.n - NID_W'(1));

    tsss_ram #(
        .WIDTH (2 * BYTE_W),
        .DEPTH (MAX_NODES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_cmd.slot[AW-1:0]),
        .i_wdata ({i_cmd.rss, i_cmd.corr}),
        .i_re    (ram_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_cur       = r_cur;
        n_cur_v     = r_cur_v;
        n_have      = r_have;
        n_out_valid = r_out_valid && !i_ready;
        n_kind      = r_kind;
        n_ch        = r_ch;
        n_fl        = r_fl;
        n_hc        = r_hc;
        n_ei        = r_ei;
        n_rss       = r_rss;
        n_corr      = r_corr;
        n_last      = r_last;
        o_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        set_valid   = 1'b0;
        clr_valid   = 1'b0;
        load        = 1'b0;
        issue       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    if (i_cmd.op == OP_STORE) begin
                        ram_we    = 1'b1;
                        set_valid = 1'b1;
                    end else if (i_cmd.ch_fire) begin
                        n_state = S_CHAN;
                    end else if (i_cmd.n != '0) begin
                        n_state = S_TX;
                        n_idx   = '0;
                        n_have  = 1'b0;
                    end else begin
                        clr_valid = 1'b1;
                    end
                end
            end
            S_CHAN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = 1'b0;
                    n_ch        = r_cmd.hop;
                    n_fl        = r_cmd.flush;
                    n_hc        = '0;
                    n_ei        = '0;
                    n_rss       = '0;
                    n_corr      = '0;
                    n_last      = !(r_cmd.tx_fire && r_cmd.n != '0);
                    if (r_cmd.tx_fire && r_cmd.n != '0) begin
                        n_state = S_TX;
                        n_idx   = '0;
                        n_have  = 1'b0;
                    end else begin
                        clr_valid = r_cmd.tx_fire;
                        n_state   = S_IDLE;
                    end
                end
            end
            S_TX: begin
                load  = r_have && out_free;
                issue = (r_idx != r_cmd.n) && (!r_have || load);
                if (load) begin
                    n_out_valid = 1'b1;
                    n_kind      = 1'b1;
                    n_ch        = r_cmd.hop;
                    n_fl        = 1'b0;
                    n_hc        = r_cmd.counter;
                    n_ei        = r_cur[EIDX_W-1:0];
                    n_rss       = r_cur_v ? ram_rdata[2*BYTE_W-1:BYTE_W] : i_hole_value;
                    n_corr      = r_cur_v ? ram_rdata[BYTE_W-1:0] : i_hole_value;
                    n_last      = entry_last;
                    n_have      = 1'b0;
                    if (entry_last) begin
                        clr_valid = 1'b1;
                        n_state   = S_IDLE;
                    end
                end
                if (issue) begin
                    ram_re  = 1'b1;
                    n_cur   = r_idx;
                    n_cur_v = r_valid[r_idx[AW-1:0]];
                    n_idx   = r_idx + NID_W'(1);
                    n_have  = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            r_state     <= n_state;
            r_have      <= n_have;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (clr_valid) begin
                r_valid <= '0;
            end else if (set_valid) begin
                r_valid[i_cmd.slot[AW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_cur   <= n_cur;
        r_cur_v <= n_cur_v;
        r_kind  <= n_kind;
        r_ch    <= n_ch;
        r_fl    <= n_fl;
        r_hc    <= n_hc;
        r_ei    <= n_ei;
        r_rss   <= n_rss;
        r_corr  <= n_corr;
        r_last  <= n_last;
    end

    assign o_valid          = r_out_valid;
    assign o_kind           = r_kind;
    assign o_channel_index  = r_ch;
    assign o_flush_rx       = r_fl;
    assign o_header_counter = r_hc;
    assign o_entry_index    = r_ei;
    assign o_entry_rss      = r_rss;
    assign o_entry_corr     = r_corr;
    assign o_last           = r_last;

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TX) |-> (r_idx <= r_cmd.n))
        else $error("entry read index beyond node count");
    a_clear_after_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && entry_last) |=> (r_valid == '0))
        else $error("entries not cleared after transmit");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE && !i_empty))
        else $error("command taken while busy");
`endif

endmodule

@@ hw/rtl/tdma_slot_sync_scheduler.sv @@
// Top level of the TDMA slot keeper: port packing and unit wiring.
//
// Input stream (s side): one beat per timer tick (tuser 0) or received packet
// (tuser 1). Packets and ticks update the timers in the cycle they are taken;
// the front end takes one beat per cycle while the four-entry command queue
// has room.
// Output stream (m side): a tick whose channel timer expires yields one
// channel-change beat (tuser 0); a tick whose transmit timer expires yields one
// beat per ring entry (tuser 1), after the channel beat when both expire.
// tlast marks the final beat caused by one input beat.
// A transmit burst of n entries runs at one beat per cycle while the m side
// accepts, through the registered entry store; a packet costs the result
// sequencer only the store write.
// Config: a write channel, always ready, index 0 node_id, 1 num_nodes,
// 2 channel_count, 3 hole_value; write only while the block is idle.
// Reset: synchronous, clears timers, counters, entry flags and the queue;
// the transmit timer starts in its first period. A stalled m side holds the
// output register; the queue then fills and s_tready drops.
module tdma_slot_sync_scheduler
    import tsss_pkg::*;
#(
    parameter int MAX_NODES    = MAX_NODES_DEF,
    parameter int SLOT_TICKS   = SLOT_TICKS_DEF,
    parameter int MISS_LIMIT   = MISS_LIMIT_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int CMDQ_DEPTH   = CMDQ_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // from_node[7:0], rx_counter[23:8], rx_rssi[31:24], rx_corr[39:32],
    // length_matches[40], zero[47:41]
    input  logic [S_DATA_W-1:0]   i_s_tdata,
    // action[0]
    input  logic                  i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // channel_index[3:0], flush_rx[4], header_counter[20:5], entry_index[25:21],
    // entry_rss[33:26], entry_corr[41:34], zero[47:42]
    output logic [M_DATA_W-1:0]   o_m_tdata,
    // kind[0]
    output logic                  o_m_tuser,
    output logic                  o_m_tlast
);

    t_cmd              f_cmd, q_cmd;
    logic              f_push, q_full, q_empty, b_pop;
    logic [BYTE_W-1:0] hole_value;
    logic [HOP_W-1:0]  m_channel_index;
    logic              m_flush_rx;
    logic [CNT_W-1:0]  m_header_counter;
    logic [EIDX_W-1:0] m_entry_index;
    logic [BYTE_W-1:0] m_entry_rss, m_entry_corr;

    assign o_cfg_ready = 1'b1;

    tsss_front #(
        .MAX_NODES    (MAX_NODES),
        .SLOT_TICKS   (SLOT_TICKS),
        .MISS_LIMIT   (MISS_LIMIT),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_s_tvalid),
        .o_ready          (o_s_tready),
        .i_action         (i_s_tuser),
        .i_from_node      (i_s_tdata[7:0]),
        .i_rx_counter     (i_s_tdata[23:8]),
        .i_rx_rssi        (i_s_tdata[31:24]),
        .i_rx_corr        (i_s_tdata[39:32]),
        .i_length_matches (i_s_tdata[40]),
        .i_full           (q_full),
        .o_push           (f_push),
        .o_cmd            (f_cmd),
        .o_hole_value     (hole_value)
    );

    tsss_cmdq #(
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cmd   (f_cmd),
        .i_pop   (b_pop),
        .o_cmd   (q_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    tsss_back #(
        .MAX_NODES (MAX_NODES)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (q_cmd),
        .i_empty          (q_empty),
        .o_pop            (b_pop),
        .i_hole_value     (hole_value),
        .o_valid          (o_m_tvalid),
        .i_ready          (i_m_tready),
        .o_kind           (o_m_tuser),
        .o_channel_index  (m_channel_index),
        .o_flush_rx       (m_flush_rx),
        .o_header_counter (m_header_counter),
        .o_entry_index    (m_entry_index),
        .o_entry_rss      (m_entry_rss),
        .o_entry_corr     (m_entry_corr),
        .o_last           (o_m_tlast)
    );

    assign o_m_tdata = {6'd0, m_entry_corr, m_entry_rss, m_entry_index,
                        m_header_counter, m_flush_rx, m_channel_index};

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for the TDMA slot keeper: scripted and random packet/tick streams.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tsss_pkg::*;

    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int HOLD_CYCLES    = 400;
    localparam int LIMIT_MAX      = (1 << TMR_W) - 1;

    typedef enum logic {
        ACT_TICK   = 1'b0,
        ACT_PACKET = 1'b1
    } t_action;

    typedef enum logic {
        KIND_CHANNEL = 1'b0,
        KIND_ENTRY   = 1'b1
    } t_kind;

    typedef struct {
        t_action           act;
        logic [FROM_W-1:0] from_node;
        logic [CNT_W-1:0]  rx_counter;
        logic [BYTE_W-1:0] rssi;
        logic [BYTE_W-1:0] corr;
        logic              len_ok;
    } t_radio_event;

    typedef struct packed {
        logic              kind;
        logic [HOP_W-1:0]  channel;
        logic              flush;
        logic [CNT_W-1:0]  header;
        logic [EIDX_W-1:0] slot;
        logic [BYTE_W-1:0] rss;
        logic [BYTE_W-1:0] corr;
        logic              last;
    } t_sched_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    t_cfg_idx              i_cfg_index = CFG_NODE_ID;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_DATA_W-1:0]   i_s_tdata = '0;
    logic                  i_s_tuser = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_DATA_W-1:0]   o_m_tdata;
    logic                  o_m_tuser;
    logic                  o_m_tlast;

    tdma_slot_sync_scheduler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    // slot keeper mirror
    logic [NID_W-1:0]  reg_node_id;
    logic [NID_W-1:0]  reg_num_nodes;
    logic [CC_W-1:0]   reg_ch_count;
    logic [BYTE_W-1:0] reg_hole;
    logic [TMR_W-1:0]  tx_count, tx_target, ch_count, ch_target;
    bit                in_first_round, tx_armed, ch_armed;
    logic [HOP_W-1:0]  hop;
    logic [MISS_W-1:0] misses;
    logic [CNT_W-1:0]  pkt_counter;
    bit                heard [MAX_NODES_DEF];
    logic [BYTE_W-1:0] heard_rss [MAX_NODES_DEF];
    logic [BYTE_W-1:0] heard_corr [MAX_NODES_DEF];

    t_radio_event radio_events [$];
    t_radio_event on_air;
    t_sched_beat  sched_out_due [$];

    int events_queued = 0;
    int events_taken = 0;
    int phase_items = 0;
    int idle_pct = 0;
    int src_gap = 0;
    int snk_gap = 0;
    logic hold_req = 1'b0;
    int hold_left = 0;
    int cycles = 0;
    int mismatches = 0;
    int beats_checked = 0;
    int pkts_taken = 0;
    int ticks_taken = 0;
    int flushes_predicted = 0;
    int settings_used = 0;

    always #5 i_clk = ~i_clk;

    function automatic logic [TMR_W-1:0] slot_limit(input int v);
        if (v <= 0) begin
            return '0;
        end
        if (v > LIMIT_MAX) begin
            return TMR_W'(LIMIT_MAX);
        end
        return TMR_W'(v);
    endfunction

    function automatic int ring_size();
        return (reg_num_nodes > MAX_NODES_DEF) ? MAX_NODES_DEF : int'(reg_num_nodes);
    endfunction

    task automatic advance_slot_keeper(input t_radio_event ev);
        int n, me, t, h;
        logic [TMR_W-1:0] reload, lim;
        bit ch_fire, tx_fire;
        t_sched_beat b;
        t_sched_beat burst [$];
        n = ring_size();
        me = reg_node_id;
        if (ev.act == ACT_PACKET) begin
            pkts_taken++;
            if (ev.len_ok) begin
                t = ev.from_node;
                tx_armed = 1'b0;
                ch_armed = 1'b0;
                misses = '0;
                if (t >= 1 && t <= n) begin
                    ch_target = slot_limit((n - t + 2) * SLOT_TICKS_DEF);
                    ch_count = '0;
                    ch_armed = 1'b1;
                    if (t > me) begin
                        tx_target = slot_limit((n - t + me - 1) * SLOT_TICKS_DEF
                                               + TX_GUARD * SLOT_TICKS_DEF);
                        pkt_counter = CNT_W'(ev.rx_counter + n - t + 1);
                    end else begin
                        tx_target = slot_limit((me - 1 - t) * SLOT_TICKS_DEF);
                        pkt_counter = CNT_W'(ev.rx_counter + me - t);
                    end
                    in_first_round = 1'b0;
                    tx_count = '0;
                    tx_armed = 1'b1;
                    heard[t-1] = 1'b1;
                    heard_rss[t-1] = ev.rssi;
                    heard_corr[t-1] = ev.corr;
                end
            end
        end else begin
            ticks_taken++;
            ch_fire = 1'b0;
            tx_fire = 1'b0;
            reload = slot_limit((n + TX_GUARD) * SLOT_TICKS_DEF);
            if (ch_armed) begin
                ch_count = ch_count + 1'b1;
                if (ch_count >= ch_target) begin
                    ch_fire = 1'b1;
                    ch_count = '0;
                end
            end
            if (tx_armed) begin
                lim = in_first_round ? slot_limit(FIRST_BASE - me * SLOT_TICKS_DEF) : tx_target;
                tx_count = tx_count + 1'b1;
                if (tx_count >= lim) begin
                    tx_fire = 1'b1;
                    tx_count = '0;
                end
            end
            if (ch_fire) begin
                b = '0;
                b.kind = KIND_CHANNEL;
                if (misses < MISS_LIMIT_DEF) begin
                    h = hop + 1;
                    if (h >= reg_ch_count || h >= MAX_CHANNELS_DEF) begin
                        h = 0;
                    end
                    hop = HOP_W'(h);
                end else begin
                    hop = '0;
                    b.flush = 1'b1;
                    flushes_predicted++;
                end
                ch_target = reload;
                b.channel = hop;
                burst.push_back(b);
            end
            if (tx_fire) begin
                for (int i = 0; i < n; i++) begin
                    b = '0;
                    b.kind = KIND_ENTRY;
                    b.channel = hop;
                    b.header = pkt_counter;
                    b.slot = EIDX_W'(i);
                    b.rss = heard[i] ? heard_rss[i] : reg_hole;
                    b.corr = heard[i] ? heard_corr[i] : reg_hole;
                    burst.push_back(b);
                end
                heard = '{default: 1'b0};
                if (misses < MISS_LIMIT_DEF) begin
                    misses = misses + 1'b1;
                end
                tx_target = reload;
                in_first_round = 1'b0;
            end
            if (burst.size() != 0) begin
                burst[burst.size()-1].last = 1'b1;
                foreach (burst[i]) begin
                    sched_out_due.push_back(burst[i]);
                end
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result beat %0d: %s expected 0x%0h, got 0x%0h",
                         beats_checked, name, want, got);
            end
        end
    endtask

    task automatic check_beat();
        t_sched_beat want;
        beats_checked++;
        if (sched_out_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result beat %0d arrived with nothing expected: tuser %0b tdata 0x%0h",
                         beats_checked, o_m_tuser, o_m_tdata);
            end
        end else begin
            want = sched_out_due.pop_front();
            check_field("kind", want.kind, o_m_tuser);
            check_field("channel_index", want.channel, o_m_tdata[3:0]);
            check_field("flush_rx", want.flush, o_m_tdata[4]);
            check_field("header_counter", want.header, o_m_tdata[20:5]);
            check_field("entry_index", want.slot, o_m_tdata[25:21]);
            check_field("entry_rss", want.rss, o_m_tdata[33:26]);
            check_field("entry_corr", want.corr, o_m_tdata[41:34]);
            check_field("last", want.last, o_m_tlast);
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                advance_slot_keeper(on_air);
                events_taken <= events_taken + 1;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (src_gap != 0) begin
                    src_gap <= src_gap - 1;
                    i_s_tvalid <= 1'b0;
                end else if ($urandom_range(99) < idle_pct) begin
                    src_gap <= $urandom_range(0, 11);
                    i_s_tvalid <= 1'b0;
                end else if (radio_events.size() != 0) begin
                    on_air = radio_events.pop_front();
                    i_s_tdata <= {7'b0, on_air.len_ok, on_air.corr, on_air.rssi,
                                  on_air.rx_counter, on_air.from_node};
                    i_s_tuser <= on_air.act;
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            snk_gap <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                check_beat();
            end
            if (hold_left != 0) begin
                i_m_tready <= 1'b0;
            end else if (snk_gap != 0) begin
                snk_gap <= snk_gap - 1;
                i_m_tready <= 1'b0;
            end else if ($urandom_range(99) < idle_pct) begin
                snk_gap <= $urandom_range(0, 11);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= TIMEOUT_CYCLES) begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycles, sched_out_due.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic push_packet(input int from, input int cnt, input int rssi, input int corr,
                               input logic len_ok);
        t_radio_event ev;
        ev.act = ACT_PACKET;
        ev.from_node = FROM_W'(from);
        ev.rx_counter = CNT_W'(cnt);
        ev.rssi = BYTE_W'(rssi);
        ev.corr = BYTE_W'(corr);
        ev.len_ok = len_ok;
        radio_events.push_back(ev);
        events_queued++;
        if (len_ok) begin
            phase_items++;
        end
    endtask

    task automatic push_ticks(input int count);
        t_radio_event ev;
        repeat (count) begin
            ev.act = ACT_TICK;
            ev.from_node = FROM_W'($urandom);
            ev.rx_counter = CNT_W'($urandom);
            ev.rssi = BYTE_W'($urandom);
            ev.corr = BYTE_W'($urandom);
            ev.len_ok = 1'($urandom);
            radio_events.push_back(ev);
            events_queued++;
            phase_items++;
        end
    endtask

    task automatic add_round();
        int n, pick, from;
        n = ring_size();
        pick = $urandom_range(0, 99);
        if (pick < 55 && n > 0) begin
            if (reg_node_id >= 2 && reg_node_id - 1 <= n && $urandom_range(0, 1) == 1) begin
                from = reg_node_id - 1;
            end else begin
                from = $urandom_range(1, n);
            end
            push_packet(from, $urandom, $urandom, $urandom, 1'b1);
            if ($urandom_range(0, 2) == 0) begin
                push_packet($urandom_range(1, n), $urandom, $urandom, $urandom, 1'b1);
            end
            push_ticks($urandom_range(1, 16));
        end else if (pick < 70) begin
            push_ticks($urandom_range(1, 30));
        end else if (pick < 82) begin
            from = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(n + 1, 255);
            push_packet(from, $urandom, $urandom, $urandom, 1'b1);
            push_ticks($urandom_range(1, 6));
        end else if (pick < 92) begin
            push_packet($urandom_range(0, 255), $urandom, $urandom, $urandom, 1'b0);
        end else begin
            push_ticks($urandom_range(10, 30));
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_NODE_ID:       reg_node_id = NID_W'(value);
            CFG_NUM_NODES:     reg_num_nodes = NID_W'(value);
            CFG_CHANNEL_COUNT: reg_ch_count = CC_W'(value);
            CFG_HOLE_VALUE:    reg_hole = BYTE_W'(value);
            default: ;
        endcase
    endtask

    task automatic settle();
        while (events_taken != events_queued) begin
            @(posedge i_clk);
        end
        while (sched_out_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input int node, input int num, input int chans, input int hole,
                             input int idle, input int target, input int opener_ticks,
                             input bit squeeze);
        write_reg(CFG_NODE_ID, node);
        write_reg(CFG_NUM_NODES, num);
        write_reg(CFG_CHANNEL_COUNT, chans);
        write_reg(CFG_HOLE_VALUE, hole);
        settings_used++;
        idle_pct = idle;
        phase_items = 0;
        if (squeeze) begin
            @(posedge i_clk);
            hold_req <= 1'b1;
            @(posedge i_clk);
            hold_req <= 1'b0;
        end
        // beat from this node's own slot: transmit due on the next tick
        if (opener_ticks > 0) begin
            push_packet(reg_node_id, $urandom, $urandom, $urandom, 1'b1);
            push_ticks(opener_ticks);
        end
        // stores queue up behind the stalled burst until the input backs up
        if (squeeze) begin
            repeat (6) begin
                push_packet($urandom_range(1, ring_size()), $urandom, $urandom, $urandom,
                            1'b1);
            end
        end
        while (phase_items < target) begin
            add_round();
        end
        settle();
    endtask

    initial begin
        reg_node_id = NODE_ID_RST;
        reg_num_nodes = NUM_NODES_RST;
        reg_ch_count = CHANNEL_COUNT_RST;
        reg_hole = HOLE_VALUE_RST;
        tx_count = '0;
        tx_target = '0;
        ch_count = '0;
        ch_target = '0;
        in_first_round = 1'b1;
        tx_armed = 1'b1;
        ch_armed = 1'b0;
        hop = '0;
        misses = '0;
        pkt_counter = '0;
        heard = '{default: 1'b0};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 25;
        settings_used = 1;

        // reset settings: wrong length with all bits set, first-period ticks
        push_packet(255, 16'hFFFF, 8'hFF, 8'hFF, 1'b0);
        push_ticks(2);
        settle();

        // late node_id shortens the first period; invalid senders stop the timers
        write_reg(CFG_NODE_ID, 36);
        settings_used++;
        push_ticks(1);
        push_packet(0, 16'h0000, 8'h00, 8'h00, 1'b1);
        push_ticks(1);
        push_packet(2, 16'hFFFF, 8'hFF, 8'hFF, 1'b1);
        push_ticks(2);
        settle();

        // two-node ring: own slot, successor wrap, stored and hole entries
        write_reg(CFG_NODE_ID, 1);
        write_reg(CFG_NUM_NODES, 2);
        write_reg(CFG_CHANNEL_COUNT, 2);
        write_reg(CFG_HOLE_VALUE, 0);
        settings_used++;
        push_packet(1, 16'hFFFF, 8'hFF, 8'h00, 1'b1);
        push_ticks(1);
        push_packet(2, 16'h1234, 8'h00, 8'hFF, 1'b1);
        push_packet(1, 16'h0000, 8'h5A, 8'hA5, 1'b1);
        push_ticks(1);
        settle();

        run_phase(1, 1, 3, 8'h81, 20, 4, 70, 1'b0);
        run_phase(0, 3, 1, 8'h00, 35, 4, 0, 1'b0);
        run_phase(5, 2, 16, 8'hFF, 0, 4, 0, 1'b0);
        run_phase(32, 32, 16, 8'hA5, 15, 4, 12, 1'b1);
        run_phase(63, 63, 31, 8'h3C, 25, 4, 0, 1'b0);
        run_phase(0, 0, 0, 8'h5A, 10, 4, 0, 1'b0);
        run_phase($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 16),
                  $urandom_range(0, 255), 30, 4, 0, 1'b0);
        run_phase(17, 20, 7, $urandom_range(0, 255), 0, 4, 16, 1'b0);

        $display("covered %0d packet beats and %0d tick beats under %0d register settings",
                 pkts_taken, ticks_taken, settings_used);
        $display("checked %0d result beats, %0d rx flushes among them, %0d mismatches",
                 beats_checked, flushes_predicted, mismatches);
        if (mismatches == 0 && sched_out_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
